>>> rtl/core/pidu_pkg.sv
// Shared constants, microcode format and program of the perturbation index decoder.
`timescale 1ns / 1ps

package pidu_pkg;

	// Field and register widths
	localparam int WORD_W     = 32;
	localparam int LS_W       = 11;
	localparam int TW_W       = 23;
	localparam int TB_W       = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;
	localparam int STEP_W     = 2;
	localparam int RNODE_W    = 10;
	localparam int WIDX_W     = 5;
	localparam int BOFF_W     = 5;
	localparam int DELTA_W    = 2;

	// Register indexes
	localparam int LAYER_REGS = 5;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_WEIGHT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BIAS   = 3'd6;

	// Parameter defaults
	localparam int DEF_MAX_LAYERS      = 5;
	localparam int DEF_MAX_LAYER_NODES = 1024;
	localparam int DEF_WORD_BITS       = 32;

	localparam logic [DELTA_W-1:0] DELTA_PLUS  = 2'b01;
	localparam logic [DELTA_W-1:0] DELTA_MINUS = 2'b11;

	localparam int PC_W = 4;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_MODLOAD,
		OP_DIV,
		OP_WALKINIT,
		OP_SIZE,
		OP_TEST,
		OP_BRANCH,
		OP_NDLOAD,
		OP_WDLOAD,
		OP_OUT
	} op_t;

	typedef enum logic [2:0] {
		COND_NEXT,
		COND_ACCEPT,
		COND_DIV,
		COND_MORE,
		COND_BIAS,
		COND_OUT
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} uword_t;

	// Datapath status seen by the sequencer
	typedef struct packed {
		logic div_last;
		logic walk_more;
		logic bias;
		logic out_free;
	} dp_status_t;

	localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
	localparam logic [PC_W-1:0] PC_SIZE = 4'd4;
	localparam logic [PC_W-1:0] PC_OUT  = 4'd10;

	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		w = '{op: OP_IDLE, cond: COND_ACCEPT, target: PC_IDLE};
		unique case (pc)
			4'd0:  w = '{op: OP_IDLE,     cond: COND_ACCEPT, target: PC_IDLE};
			4'd1:  w = '{op: OP_MODLOAD,  cond: COND_NEXT,   target: PC_IDLE};
			4'd2:  w = '{op: OP_DIV,      cond: COND_DIV,    target: PC_IDLE};
			4'd3:  w = '{op: OP_WALKINIT, cond: COND_NEXT,   target: PC_IDLE};
			4'd4:  w = '{op: OP_SIZE,     cond: COND_NEXT,   target: PC_IDLE};
			4'd5:  w = '{op: OP_TEST,     cond: COND_MORE,   target: PC_SIZE};
			4'd6:  w = '{op: OP_BRANCH,   cond: COND_BIAS,   target: PC_OUT};
			4'd7:  w = '{op: OP_NDLOAD,   cond: COND_NEXT,   target: PC_IDLE};
			4'd8:  w = '{op: OP_DIV,      cond: COND_DIV,    target: PC_IDLE};
			4'd9:  w = '{op: OP_WDLOAD,   cond: COND_NEXT,   target: PC_IDLE};
			4'd10: w = '{op: OP_OUT,      cond: COND_OUT,    target: PC_IDLE};
			default: w = '{op: OP_IDLE,   cond: COND_ACCEPT, target: PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

>>> rtl/core/pidu_cfg_regs.sv
// Configuration registers with effective layer sizes and totals.
`timescale 1ns / 1ps

module pidu_cfg_regs
	import pidu_pkg::*;
#(
	parameter int MAX_LAYERS      = DEF_MAX_LAYERS,
	parameter int MAX_LAYER_NODES = DEF_MAX_LAYER_NODES,
	localparam int NODE_W = $clog2(MAX_LAYER_NODES + 1),
	localparam int LIDX_W = $clog2(MAX_LAYERS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [LIDX_W-1:0]     rd_idx,
	output logic [NODE_W-1:0]     eff_first,
	output logic [NODE_W-1:0]     eff_rd,
	output logic [TW_W-1:0]       tot_weight,
	output logic [TB_W-1:0]       tot_bias
);

	logic [LS_W-1:0]   layer_size_q [MAX_LAYERS];
	logic [TW_W-1:0]   tot_weight_q;
	logic [TB_W-1:0]   tot_bias_q;
	logic [NODE_W-1:0] eff [MAX_LAYERS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_LAYERS; i++) begin
				layer_size_q[i] <= LS_W'(1);
			end
			tot_weight_q <= TW_W'(1);
			tot_bias_q   <= TB_W'(1);
		end else if (cfg_wr_en) begin
			for (int i = 0; i < MAX_LAYERS; i++) begin
				if (i < LAYER_REGS && cfg_index == CFG_IDX_W'(i)) begin
					layer_size_q[i] <= cfg_data[LS_W-1:0];
				end
			end
			if (cfg_index == REG_TOTAL_WEIGHT) begin
				tot_weight_q <= cfg_data[TW_W-1:0];
			end
			if (cfg_index == REG_TOTAL_BIAS) begin
				tot_bias_q <= cfg_data[TB_W-1:0];
			end
		end
	end

	// Zero acts as one, oversize clamps to the node limit
	always_comb begin
		for (int i = 0; i < MAX_LAYERS; i++) begin
			if (layer_size_q[i] == '0) begin
				eff[i] = NODE_W'(1);
			end else if (32'(layer_size_q[i]) > MAX_LAYER_NODES) begin
				eff[i] = NODE_W'(MAX_LAYER_NODES);
			end else begin
				eff[i] = NODE_W'(layer_size_q[i]);
			end
		end
	end

	assign eff_first  = eff[0];
	assign eff_rd     = eff[rd_idx];
	assign tot_weight = (tot_weight_q == '0) ? TW_W'(1) : tot_weight_q;
	assign tot_bias   = (tot_bias_q == '0) ? TB_W'(1) : tot_bias_q;

endmodule

>>> rtl/core/pidu_sequencer.sv
// Microcode sequencer: step counter, control store and jump logic.
`timescale 1ns / 1ps

module pidu_sequencer
	import pidu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  dp_status_t status,
	output op_t        op,
	output logic       in_ready
);

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_d;
	uword_t          uw;

	assign uw       = ucode(pc_q);
	assign op       = uw.op;
	assign in_ready = (uw.op == OP_IDLE);

	always_comb begin
		pc_d = PC_W'(pc_q + 1'b1);
		unique case (uw.cond)
			COND_NEXT: begin
			end
			COND_ACCEPT: begin
				if (!in_valid) pc_d = pc_q;
			end
			COND_DIV: begin
				if (!status.div_last) pc_d = pc_q;
			end
			COND_MORE: begin
				if (status.walk_more) pc_d = uw.target;
			end
			COND_BIAS: begin
				if (status.bias) pc_d = uw.target;
			end
			COND_OUT: begin
				pc_d = status.out_free ? uw.target : pc_q;
			end
			default: pc_d = PC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

>>> rtl/core/pidu_datapath.sv
// Datapath: shared restoring divider, layer walk and output register.
`timescale 1ns / 1ps

module pidu_datapath
	import pidu_pkg::*;
#(
	parameter int MAX_LAYERS      = DEF_MAX_LAYERS,
	parameter int MAX_LAYER_NODES = DEF_MAX_LAYER_NODES,
	parameter int WORD_BITS       = DEF_WORD_BITS,
	localparam int NODE_W = $clog2(MAX_LAYER_NODES + 1),
	localparam int LIDX_W = $clog2(MAX_LAYERS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  op_t                op,
	input  logic               in_valid,
	input  logic               mode,
	input  logic [WORD_W-1:0]  random_word,
	input  logic               sign_bit,
	input  logic [NODE_W-1:0]  eff_first,
	input  logic [NODE_W-1:0]  eff_rd,
	input  logic [TW_W-1:0]    tot_weight,
	input  logic [TB_W-1:0]    tot_bias,
	output logic [LIDX_W-1:0]  rd_idx,
	output dp_status_t         status,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               kind,
	output logic [STEP_W-1:0]  layer_step,
	output logic [RNODE_W-1:0] right_node,
	output logic [WIDX_W-1:0]  word_index,
	output logic [BOFF_W-1:0]  bit_offset,
	output logic [DELTA_W-1:0] bias_delta
);

	localparam int SIZE_W  = 2 * NODE_W;
	localparam int CMP_W   = (SIZE_W > WORD_W) ? SIZE_W : WORD_W;
	localparam int CNT_W   = $clog2(WORD_W + 1);
	// Quotient bits of the node divide: value < 2**NODE_QW times divisor
	localparam int NODE_QW = $clog2(MAX_LAYER_NODES);
	// WORD_BITS is a power of two: split the word index and bit offset by shift and mask
	localparam int               WB_SH   = $clog2(WORD_BITS);
	localparam logic [WORD_W-1:0] WB_MASK = WORD_W'(WORD_BITS - 1);

	logic               mode_q;
	logic               sign_q;
	logic [WORD_W-1:0]  val_q;
	logic [WORD_W-1:0]  rem_q;
	logic [WORD_W-1:0]  quo_q;
	logic [WORD_W-1:0]  dvsr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [LIDX_W-1:0]  s_q;
	logic [NODE_W-1:0]  cur_q;
	logic [NODE_W-1:0]  next_q;
	logic [SIZE_W-1:0]  size_q;
	logic [RNODE_W-1:0] rnode_q;
	logic               out_valid_q;

	logic [WORD_W:0] div_sh;
	logic            div_ge;
	logic [WORD_W:0] div_sub;
	logic [CMP_W-1:0] val_x;
	logic [CMP_W-1:0] size_x;
	logic            fits;
	logic            last;
	logic            out_free;

	assign div_sh  = {rem_q, quo_q[WORD_W-1]};
	assign div_ge  = div_sh >= {1'b0, dvsr_q};
	assign div_sub = div_sh - {1'b0, dvsr_q};

	assign val_x  = CMP_W'(val_q);
	assign size_x = CMP_W'(size_q);
	assign fits   = val_x < size_x;
	assign last   = (s_q == LIDX_W'(MAX_LAYERS - 2));

	assign rd_idx   = LIDX_W'(s_q + 1'b1);
	assign out_free = !out_valid_q || out_ready;

	assign status.div_last  = (cnt_q == CNT_W'(1));
	assign status.walk_more = !fits && !last;
	assign status.bias      = mode_q;
	assign status.out_free  = out_free;

	always_ff @(posedge clk) begin
		unique case (op)
			OP_IDLE: begin
				if (in_valid) begin
					mode_q <= mode;
					sign_q <= sign_bit;
					quo_q  <= random_word;
				end
			end
			OP_MODLOAD: begin
				rem_q  <= '0;
				cnt_q  <= CNT_W'(WORD_W);
				dvsr_q <= mode_q ? WORD_W'(tot_bias) : WORD_W'(tot_weight);
			end
			OP_DIV: begin
				rem_q <= div_ge ? div_sub[WORD_W-1:0] : div_sh[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], div_ge};
				cnt_q <= CNT_W'(cnt_q - 1'b1);
			end
			OP_WALKINIT: begin
				val_q <= rem_q;
				s_q   <= '0;
				cur_q <= eff_first;
			end
			OP_SIZE: begin
				next_q <= eff_rd;
				size_q <= mode_q ? SIZE_W'(eff_rd) : SIZE_W'(cur_q) * SIZE_W'(eff_rd);
			end
			OP_TEST: begin
				if (!fits) begin
					if (last) begin
						// saturate to the last element of the final step
						val_q <= WORD_W'(size_x - 1'b1);
					end else begin
						val_q <= WORD_W'(val_x - size_x);
						s_q   <= LIDX_W'(s_q + 1'b1);
						cur_q <= next_q;
					end
				end
			end
			OP_BRANCH: begin
				rnode_q <= val_q[RNODE_W-1:0];
			end
			OP_NDLOAD: begin
				dvsr_q <= WORD_W'(next_q);
				rem_q  <= val_q >> NODE_QW;
				quo_q  <= val_q << (WORD_W - NODE_QW);
				cnt_q  <= CNT_W'(NODE_QW);
			end
			OP_WDLOAD: begin
				rnode_q <= quo_q[RNODE_W-1:0];
				quo_q   <= rem_q >> WB_SH;
				rem_q   <= rem_q & WB_MASK;
			end
			OP_OUT: begin
				if (out_free) begin
					kind       <= mode_q;
					layer_step <= STEP_W'(s_q);
					right_node <= rnode_q;
					word_index <= mode_q ? '0 : quo_q[WIDX_W-1:0];
					bit_offset <= mode_q ? '0 : rem_q[BOFF_W-1:0];
					bias_delta <= mode_q ? (sign_q ? DELTA_PLUS : DELTA_MINUS) : '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == OP_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/core/perturbation_index_decoder_unit.sv
// An accepted item is reduced modulo the weight or bias total; the layer walk then finds its
// step, advancing at most MAX_LAYERS - 2 times. A weight item is then divided by the right
// layer size. The shared divider gives one quotient bit per cycle for both divides.
// Throughput: one item at a time; the next item is taken the cycle after the result
// register loads, while the result waits; a result not yet taken holds the next one.
// Reset: asynchronous, active low; config registers go to 1, sequencer to idle, output empty.
`timescale 1ns / 1ps

module perturbation_index_decoder_unit
	import pidu_pkg::*;
#(
	parameter int MAX_LAYERS      = DEF_MAX_LAYERS,
	parameter int MAX_LAYER_NODES = DEF_MAX_LAYER_NODES,
	parameter int WORD_BITS       = DEF_WORD_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  mode,
	input  logic [WORD_W-1:0]     random_word,
	input  logic                  sign_bit,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  kind,
	output logic [STEP_W-1:0]     layer_step,
	output logic [RNODE_W-1:0]    right_node,
	output logic [WIDX_W-1:0]     word_index,
	output logic [BOFF_W-1:0]     bit_offset,
	output logic [DELTA_W-1:0]    bias_delta
);

	localparam int NODE_W = $clog2(MAX_LAYER_NODES + 1);
	localparam int LIDX_W = $clog2(MAX_LAYERS);

	op_t               op;
	dp_status_t        status;
	logic [LIDX_W-1:0] rd_idx;
	logic [NODE_W-1:0] eff_first;
	logic [NODE_W-1:0] eff_rd;
	logic [TW_W-1:0]   tot_weight;
	logic [TB_W-1:0]   tot_bias;

	pidu_cfg_regs #(
		.MAX_LAYERS      (MAX_LAYERS),
		.MAX_LAYER_NODES (MAX_LAYER_NODES)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.rd_idx     (rd_idx),
		.eff_first  (eff_first),
		.eff_rd     (eff_rd),
		.tot_weight (tot_weight),
		.tot_bias   (tot_bias)
	);

	pidu_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.op       (op),
		.in_ready (in_ready)
	);

	pidu_datapath #(
		.MAX_LAYERS      (MAX_LAYERS),
		.MAX_LAYER_NODES (MAX_LAYER_NODES),
		.WORD_BITS       (WORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.in_valid    (in_valid),
		.mode        (mode),
		.random_word (random_word),
		.sign_bit    (sign_bit),
		.eff_first   (eff_first),
		.eff_rd      (eff_rd),
		.tot_weight  (tot_weight),
		.tot_bias    (tot_bias),
		.rd_idx      (rd_idx),
		.status      (status),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.layer_step  (layer_step),
		.right_node  (right_node),
		.word_index  (word_index),
		.bit_offset  (bit_offset),
		.bias_delta  (bias_delta)
	);

endmodule
